// File: rtl/imcc_pkg.sv
// Shared types, codes and decode logic for the instruction-mix CPI counter.
`default_nettype none

package imcc_pkg;

    localparam int NUM_CAT   = 8;
    localparam int SEL_W     = 3;
    localparam int CAT_W     = 4;
    localparam int COST_W    = 4;
    localparam int AVG_W     = 4;
    localparam int OUT_TOT_W = 32;
    localparam int OPCODE_W  = 6;
    localparam int CFG_IDX_W = 8;
    localparam int DIV_STEPS = 4;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [CAT_W-1:0] CAT_ALU       = 4'd0;
    localparam logic [CAT_W-1:0] CAT_SHIFT     = 4'd1;
    localparam logic [CAT_W-1:0] CAT_SHIFT_ALU = 4'd2;
    localparam logic [CAT_W-1:0] CAT_MEMORY    = 4'd3;
    localparam logic [CAT_W-1:0] CAT_MEM_ALU   = 4'd4;
    localparam logic [CAT_W-1:0] CAT_BRANCH    = 4'd5;
    localparam logic [CAT_W-1:0] CAT_JUMP      = 4'd6;
    localparam logic [CAT_W-1:0] CAT_HALT      = 4'd7;
    localparam logic [CAT_W-1:0] CAT_NONE      = 4'd8;

    localparam logic [COST_W-1:0] COST_RESET [NUM_CAT] = '{
        4'd4, 4'd4, 4'd5, 4'd5, 4'd6, 4'd3, 4'd3, 4'd3
    };

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_ACCUM  = 4'b0010,
        S_DIVIDE = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    typedef struct packed {
        logic             record_load;
        logic             query_start;
        logic             accum_en;
        logic             div_en;
        logic             query_load;
        logic [SEL_W-1:0] sel;
    } t_cmd;

    typedef struct packed {
        logic total_zero;
    } t_status;

    function automatic logic [CAT_W-1:0] decode_opcode(input logic [OPCODE_W-1:0] op);
        logic [CAT_W-1:0] cat;
        cat = CAT_NONE;
        case (op)
            6'h00, 6'h01, 6'h02, 6'h03, 6'h08, 6'h0A, 6'h0B: cat = CAT_ALU;
            6'h04, 6'h05, 6'h06, 6'h07,
            6'h0C, 6'h0D, 6'h0E, 6'h0F:                      cat = CAT_SHIFT;
            6'h10, 6'h11:                                    cat = CAT_BRANCH;
            6'h13:                                           cat = CAT_HALT;
            6'h14, 6'h15, 6'h16, 6'h17:                      cat = CAT_JUMP;
            6'h18, 6'h19, 6'h1A, 6'h1B,
            6'h1C, 6'h1D, 6'h1E, 6'h1F:                      cat = CAT_SHIFT_ALU;
            6'h20, 6'h21:                                    cat = CAT_MEMORY;
            6'h30, 6'h31, 6'h32, 6'h33, 6'h34, 6'h35, 6'h36, 6'h37,
            6'h3C, 6'h3E, 6'h3F:                             cat = CAT_MEM_ALU;
            default:                                         cat = CAT_NONE;
        endcase
        return cat;
    endfunction

endpackage

`default_nettype wire

// File: rtl/instruction_mix_cpi_counter_core.sv
// Top level of the instruction-mix CPI counter.
// A record word (tuser low) is answered from the idle state, and records may follow
// back to back, one per clock, as long as the result side keeps taking words. A
// query word (tuser high) walks the eight counters through one shared
// count-by-cost multiplier and accumulator, then runs a restoring divider
// producing one quotient bit per cycle; a query with nothing counted skips both
// and goes straight to the result. Counters saturate and clear only at reset;
// cost registers may be written over the config channel while idle.
`default_nettype none

module instruction_mix_cpi_counter_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [5:0] opcode, [7:6] zero
    input  wire logic        i_s_axis_tuser,   // [0] command
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,   // [3:0] category, [7:4] cycles_avg,
                                               // [39:8] total_count
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [3:0]  i_cfg_data
);

    imcc_pkg::t_cmd    cmd;
    imcc_pkg::t_status status;
    logic [imcc_pkg::CAT_W-1:0]     out_cat;
    logic [imcc_pkg::AVG_W-1:0]     out_avg;
    logic [imcc_pkg::OUT_TOT_W-1:0] out_total;

    assign o_cfg_ready = 1'b1;

    imcc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_s_cmd   (i_s_axis_tuser),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    imcc_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_opcode      (i_s_axis_tdata[imcc_pkg::OPCODE_W-1:0]),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_category    (out_cat),
        .o_cycles_avg  (out_avg),
        .o_total_count (out_total)
    );

    assign o_m_axis_tdata = {out_total, out_avg, out_cat};

endmodule

`default_nettype wire

// File: rtl/imcc_ctrl.sv
// Sequencer for the CPI counter: handshakes, query accumulate and divide steps.
`default_nettype none

module imcc_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_valid,
    input  wire logic            i_s_cmd,
    output logic                 o_s_ready,
    output logic                 o_m_valid,
    input  wire logic            i_m_ready,
    input  wire imcc_pkg::t_status i_status,
    output imcc_pkg::t_cmd       o_cmd
);

    imcc_pkg::t_state           r_state, n_state;
    logic [imcc_pkg::SEL_W-1:0] r_step, n_step;
    logic                       r_out_valid, n_out_valid;
    logic                       out_free;
    logic                       accept;

    assign out_free  = !r_out_valid || i_m_ready;
    assign o_s_ready = (r_state == imcc_pkg::S_IDLE) && out_free;
    assign accept    = i_s_valid && o_s_ready;
    assign o_m_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_m_ready;
        o_cmd       = '0;
        o_cmd.sel   = r_step;
        case (r_state)
            imcc_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_s_cmd == imcc_pkg::CMD_QUERY) begin
                        o_cmd.query_start = 1'b1;
                        n_step            = '0;
                        // nothing counted: skip straight to the result
                        n_state = i_status.total_zero ? imcc_pkg::S_DONE : imcc_pkg::S_ACCUM;
                    end else begin
                        o_cmd.record_load = 1'b1;
                        n_out_valid       = 1'b1;
                    end
                end
            end
            imcc_pkg::S_ACCUM: begin
                o_cmd.accum_en = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == imcc_pkg::SEL_W'(imcc_pkg::NUM_CAT - 1)) begin
                    n_step  = '0;
                    n_state = imcc_pkg::S_DIVIDE;
                end
            end
            imcc_pkg::S_DIVIDE: begin
                o_cmd.div_en = 1'b1;
                n_step       = r_step + 1'b1;
                if (r_step == imcc_pkg::SEL_W'(imcc_pkg::DIV_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = imcc_pkg::S_DONE;
                end
            end
            imcc_pkg::S_DONE: begin
                if (out_free) begin
                    o_cmd.query_load = 1'b1;
                    n_out_valid      = 1'b1;
                    n_state          = imcc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = imcc_pkg::S_IDLE;
                n_step  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= imcc_pkg::S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// File: rtl/imcc_dp.sv
// Datapath for the CPI counter: counters, cost registers, weighted sum, divider.
`default_nettype none

module imcc_dp #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire imcc_pkg::t_cmd                    i_cmd,
    output imcc_pkg::t_status                      o_status,
    input  wire logic [imcc_pkg::OPCODE_W-1:0]     i_opcode,
    input  wire logic                              i_cfg_valid,
    input  wire logic [imcc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [imcc_pkg::COST_W-1:0]       i_cfg_data,
    output logic [imcc_pkg::CAT_W-1:0]             o_category,
    output logic [imcc_pkg::AVG_W-1:0]             o_cycles_avg,
    output logic [imcc_pkg::OUT_TOT_W-1:0]         o_total_count
);

    localparam int TW = COUNT_WIDTH + 3;          // exact sum of eight counters
    localparam int PW = COUNT_WIDTH + imcc_pkg::COST_W;
    localparam int WW = TW + imcc_pkg::AVG_W;     // weighted sum, below 16x total

    logic [COUNT_WIDTH-1:0]        r_count [imcc_pkg::NUM_CAT];
    logic [imcc_pkg::COST_W-1:0]   r_cost  [imcc_pkg::NUM_CAT];
    logic [TW-1:0]                 r_total;
    logic [WW-1:0]                 r_acc;
    logic [imcc_pkg::AVG_W-1:0]    r_quot;
    logic [imcc_pkg::CAT_W-1:0]    r_out_cat;
    logic [imcc_pkg::AVG_W-1:0]    r_out_avg;
    logic [imcc_pkg::OUT_TOT_W-1:0] r_out_total;

    logic [imcc_pkg::CAT_W-1:0]    rec_cat;
    logic [imcc_pkg::NUM_CAT-1:0]  inc;
    logic [TW-1:0]                 n_total;
    logic [PW-1:0]                 prod;
    logic [WW-1:0]                 div_shifted;
    logic                          div_ge;
    logic [1:0]                    div_bit;

    function automatic logic [imcc_pkg::OUT_TOT_W-1:0] sat_total(input logic [TW-1:0] t);
        if ((t >> imcc_pkg::OUT_TOT_W) != '0)
            return '1;
        return imcc_pkg::OUT_TOT_W'(t);
    endfunction

    assign rec_cat = imcc_pkg::decode_opcode(i_opcode);

    always_comb begin
        for (int k = 0; k < imcc_pkg::NUM_CAT; k++) begin
            inc[k] = (rec_cat == imcc_pkg::CAT_W'(k)) && (r_count[k] != '1);
        end
    end

    assign n_total = r_total + TW'(|inc);
    assign o_status.total_zero = (r_total == '0);

    assign prod = PW'(r_count[i_cmd.sel]) * PW'(r_cost[i_cmd.sel]);

    // restoring divide, quotient MSB first
    assign div_bit     = ~i_cmd.sel[1:0];
    assign div_shifted = WW'(r_total) << div_bit;
    assign div_ge      = (r_acc >= div_shifted);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < imcc_pkg::NUM_CAT; k++) begin
                r_count[k] <= '0;
                r_cost[k]  <= imcc_pkg::COST_RESET[k];
            end
            r_total <= '0;
        end else begin
            if (i_cfg_valid && (i_cfg_index < imcc_pkg::CFG_IDX_W'(imcc_pkg::NUM_CAT))) begin
                r_cost[i_cfg_index[imcc_pkg::SEL_W-1:0]] <= i_cfg_data;
            end
            if (i_cmd.record_load) begin
                for (int k = 0; k < imcc_pkg::NUM_CAT; k++) begin
                    if (inc[k]) begin
                        r_count[k] <= r_count[k] + 1'b1;
                    end
                end
                r_total <= n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_start) begin
            r_acc <= '0;
        end else if (i_cmd.accum_en) begin
            r_acc <= r_acc + WW'(prod);
        end else if (i_cmd.div_en && div_ge) begin
            r_acc <= r_acc - div_shifted;
        end
        if (i_cmd.div_en) begin
            r_quot <= {r_quot[imcc_pkg::AVG_W-2:0], div_ge};
        end
        if (i_cmd.record_load) begin
            r_out_cat   <= rec_cat;
            r_out_avg   <= '0;
            r_out_total <= sat_total(n_total);
        end else if (i_cmd.query_load) begin
            r_out_cat   <= imcc_pkg::CAT_NONE;
            r_out_avg   <= o_status.total_zero ? '0 : r_quot;
            r_out_total <= sat_total(r_total);
        end
    end

    assign o_category    = r_out_cat;
    assign o_cycles_avg  = r_out_avg;
    assign o_total_count = r_out_total;

endmodule

`default_nettype wire

// File: rtl/imcc_checker.sv
// Port-level checks for the CPI counter, bound to the top level.
`default_nettype none

module imcc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [39:0] o_m_axis_tdata
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("result word changed while stalled");

    // never take a new word while a stalled result is still held
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_s_axis_tready && o_m_axis_tvalid) |-> i_m_axis_tready)
        else $error("input taken while output register blocked");

    a_cat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[3:0] <= imcc_pkg::CAT_NONE))
        else $error("category out of range");

    // a recorded instruction reports no average
    a_record_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[3:0] != imcc_pkg::CAT_NONE))
            |-> (o_m_axis_tdata[7:4] == 4'd0))
        else $error("record result carries an average");

    a_empty_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[39:8] == 32'd0)) |-> (o_m_axis_tdata[7:4] == 4'd0))
        else $error("nonzero average with nothing counted");

endmodule

bind instruction_mix_cpi_counter_core imcc_checker u_imcc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
